[rtl/grpm_pkg.sv]
// shared types, constants and register codes of the gain ramp with peak meter
// no dependencies
`timescale 1ns / 1ps

package grpm_pkg;

  localparam int SAMPLE_BITS    = 24;
  localparam int GAIN_FRAC_BITS = 15;
  localparam int MAX_CHANNELS   = 2;

  localparam int GAIN_W = GAIN_FRAC_BITS + 1;
  localparam int CFG_W  = 16;
  localparam int RAMP_W = ((GAIN_W > CFG_W) ? GAIN_W : CFG_W) + 2;
  localparam int PROD_W = SAMPLE_BITS + GAIN_W + 1;

  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_GAIN  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RAMP_STEP    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_METER_ENABLE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_STEREO       = 2'd3;

  localparam logic [GAIN_W-1:0] UNITY_GAIN  = GAIN_W'(1) << GAIN_FRAC_BITS;
  localparam logic [CFG_W-1:0]  RESET_TARGET = 16'd32768;
  localparam logic [CFG_W-1:0]  RESET_STEP   = 16'd137;

  localparam logic REQ_AUDIO = 1'b0;
  localparam logic REQ_PEAK  = 1'b1;

  typedef logic signed [SAMPLE_BITS-1:0] smp_t;
  typedef logic [SAMPLE_BITS-1:0]        mag_t;
  typedef logic [GAIN_W-1:0]             gain_t;
  typedef logic signed [PROD_W-1:0]      prod_t;

  typedef struct packed {
    logic req_type;
    smp_t left_sample;
    smp_t right_sample;
    logic left_invalid;
    logic right_invalid;
  } grpm_in_t;

  typedef struct packed {
    smp_t left_out;
    smp_t right_out;
    mag_t peak_level;
  } grpm_out_t;

  // control from the pipeline to the merge stage
  typedef struct packed {
    logic load;
    logic take_peak;
    logic meter_on;
    logic clear;
  } grpm_peak_ctl_t;

endpackage

[rtl/grpm_gain_ramp.sv]
// running gain register, stepped toward the clamped target once per audio frame
// depends on grpm_pkg
`timescale 1ns / 1ps

module grpm_gain_ramp (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     step_en,
  input  logic [grpm_pkg::CFG_W-1:0] target_gain,
  input  logic [grpm_pkg::CFG_W-1:0] ramp_step,
  output grpm_pkg::gain_t          gain_new
);
  import grpm_pkg::*;

  gain_t gain_now_r;
  gain_t gain_now_nxt;

  logic signed [RAMP_W-1:0] tgt;
  logic signed [RAMP_W-1:0] cur;
  logic signed [RAMP_W-1:0] stp;
  logic signed [RAMP_W-1:0] diff;
  logic signed [RAMP_W-1:0] moved;

  always_comb begin
    // targets above unity act as unity
    if (RAMP_W'(target_gain) > RAMP_W'(UNITY_GAIN)) begin
      tgt = RAMP_W'(UNITY_GAIN);
    end else begin
      tgt = RAMP_W'(target_gain);
    end
    cur  = RAMP_W'(gain_now_r);
    stp  = RAMP_W'(ramp_step);
    diff = tgt - cur;
    if (diff > stp) begin
      moved = cur + stp;
    end else if (diff < -stp) begin
      moved = cur - stp;
    end else begin
      moved = tgt;
    end
    gain_new     = moved[GAIN_W-1:0];
    gain_now_nxt = step_en ? gain_new : gain_now_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_now_r <= UNITY_GAIN;
    end else begin
      gain_now_r <= gain_now_nxt;
    end
  end

endmodule

[rtl/grpm_lane.sv]
// one channel lane: operand register, registered multiply, floor shift and magnitude
// depends on grpm_pkg
`timescale 1ns / 1ps

module grpm_lane (
  input  logic            clk,
  input  logic            ld1,
  input  logic            ld2,
  input  grpm_pkg::smp_t  smp_in,
  input  logic            act_in,
  input  grpm_pkg::gain_t gain_in,
  output grpm_pkg::smp_t  scaled,
  output grpm_pkg::mag_t  mag
);
  import grpm_pkg::*;

  smp_t  smp_r;
  gain_t gain_r;
  logic  act1_r;
  prod_t prod_r;
  logic  act2_r;
  prod_t prod_nxt;
  prod_t shifted;

  assign prod_nxt = prod_t'(smp_r) * prod_t'($signed({1'b0, gain_r}));

  always_ff @(posedge clk) begin
    if (ld1) begin
      smp_r  <= smp_in;
      gain_r <= gain_in;
      act1_r <= act_in;
    end
    if (ld2) begin
      prod_r <= prod_nxt;
      act2_r <= act1_r;
    end
  end

  always_comb begin
    // arithmetic shift rounds toward minus infinity
    shifted = prod_r >>> GAIN_FRAC_BITS;
    scaled  = act2_r ? $signed(shifted[SAMPLE_BITS-1:0]) : '0;
    mag     = scaled[SAMPLE_BITS-1] ? mag_t'(-scaled) : mag_t'(scaled);
  end

endmodule

[rtl/grpm_peak_merge.sv]
// merges lane magnitudes into the held peak and registers the result beat
// depends on grpm_pkg
`timescale 1ns / 1ps

module grpm_peak_merge (
  input  logic                    clk,
  input  logic                    rst_n,
  input  grpm_pkg::grpm_peak_ctl_t ctl,
  input  grpm_pkg::smp_t          scaled_l,
  input  grpm_pkg::smp_t          scaled_r,
  input  grpm_pkg::mag_t          mag_l,
  input  grpm_pkg::mag_t          mag_r,
  output grpm_pkg::grpm_out_t     out_data
);
  import grpm_pkg::*;

  mag_t      peak_r;
  mag_t      peak_nxt;
  mag_t      fpeak;
  mag_t      peak_upd;
  grpm_out_t out_r;
  grpm_out_t out_nxt;

  always_comb begin
    fpeak = (mag_r > mag_l) ? mag_r : mag_l;
    if (!ctl.meter_on) begin
      peak_upd = '0;
    end else if (fpeak > peak_r) begin
      peak_upd = fpeak;
    end else begin
      peak_upd = peak_r;
    end

    peak_nxt          = peak_r;
    out_nxt           = out_r;
    out_nxt.left_out  = scaled_l;
    out_nxt.right_out = scaled_r;
    if (ctl.take_peak) begin
      out_nxt.peak_level = peak_r;
    end else begin
      out_nxt.peak_level = peak_upd;
    end

    if (ctl.clear) begin
      peak_nxt = '0;
    end else if (ctl.load) begin
      peak_nxt = ctl.take_peak ? '0 : peak_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      peak_r <= '0;
    end else begin
      peak_r <= peak_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      out_r <= out_nxt;
    end
  end

  assign out_data = out_r;

endmodule

[rtl/gain_ramp_with_peak_meter_core.sv]
// top level: config registers, pipeline control, gain ramp, channel lanes, peak merge
// depends on grpm_pkg, grpm_gain_ramp, grpm_lane, grpm_peak_merge
`timescale 1ns / 1ps
//
//  port group   direction  handshake          payload
//  in_*         input      in_valid/in_stall  grpm_in_t (frame or take-peak request)
//  out_*        output     out_valid/out_stall grpm_out_t (scaled samples, peak)
//  cfg_*        input      cfg_we             cfg_index, cfg_wdata
//
//  one beat per cycle while out_stall is low; each beat goes from input to output via
//  ramp and operand register, then the lane multipliers, then peak merge and output.
//  each stage holds its beat while the stage after it is full and stalled, so beats
//  are still taken in while the result waits, until every stage is full. synchronous
//  active-low reset restores unity gain, clears the peak and empties the pipeline.

module gain_ramp_with_peak_meter_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  grpm_pkg::grpm_in_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output grpm_pkg::grpm_out_t                 out_data,
  input  logic                                cfg_we,
  input  logic [grpm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [grpm_pkg::CFG_W-1:0]          cfg_wdata
);
  import grpm_pkg::*;

  logic [CFG_W-1:0] target_gain_r;
  logic [CFG_W-1:0] ramp_step_r;
  logic             meter_en_r;
  logic             stereo_r;

  logic v1_r, v2_r, out_valid_r;
  logic req1_r, req2_r;
  logic ld1, ld2, ld_out;
  logic two_ch;
  logic meter_clear;
  gain_t gain_new;

  smp_t lane_smp    [2];
  logic lane_act    [2];
  smp_t lane_scaled [2];
  mag_t lane_mag    [2];

  grpm_peak_ctl_t peak_ctl;

  // handshake chain, output side first
  assign ld_out    = v2_r && (!out_valid_r || !out_stall);
  assign ld2       = v1_r && (!v2_r || ld_out);
  assign in_stall  = v1_r && !ld2;
  assign ld1       = in_valid && !in_stall;
  assign out_valid = out_valid_r;

  assign two_ch      = stereo_r && (MAX_CHANNELS >= 2);
  assign meter_clear = cfg_we && (cfg_index == CFG_METER_ENABLE) && !cfg_wdata[0];

  always_comb begin
    lane_smp[0] = in_data.left_sample;
    lane_smp[1] = in_data.right_sample;
    lane_act[0] = (in_data.req_type == REQ_AUDIO) && !in_data.left_invalid;
    lane_act[1] = (in_data.req_type == REQ_AUDIO) && two_ch && !in_data.right_invalid;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_gain_r <= RESET_TARGET;
      ramp_step_r   <= RESET_STEP;
      meter_en_r    <= 1'b0;
      stereo_r      <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TARGET_GAIN:  target_gain_r <= cfg_wdata;
        CFG_RAMP_STEP:    ramp_step_r   <= cfg_wdata;
        CFG_METER_ENABLE: meter_en_r    <= cfg_wdata[0];
        CFG_STEREO:       stereo_r      <= cfg_wdata[0];
        default:          ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (ld1) begin
        v1_r <= 1'b1;
      end else if (ld2) begin
        v1_r <= 1'b0;
      end
      if (ld2) begin
        v2_r <= 1'b1;
      end else if (ld_out) begin
        v2_r <= 1'b0;
      end
      if (ld_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld1) begin
      req1_r <= in_data.req_type;
    end
    if (ld2) begin
      req2_r <= req1_r;
    end
  end

  // gain moves only on accepted audio frames
  grpm_gain_ramp u_ramp (
    .clk         (clk),
    .rst_n       (rst_n),
    .step_en     (ld1 && (in_data.req_type == REQ_AUDIO)),
    .target_gain (target_gain_r),
    .ramp_step   (ramp_step_r),
    .gain_new    (gain_new)
  );

  for (genvar l = 0; l < 2; l++) begin : g_lane
    if (l < MAX_CHANNELS) begin : g_on
      grpm_lane u_lane (
        .clk     (clk),
        .ld1     (ld1),
        .ld2     (ld2),
        .smp_in  (lane_smp[l]),
        .act_in  (lane_act[l]),
        .gain_in (gain_new),
        .scaled  (lane_scaled[l]),
        .mag     (lane_mag[l])
      );
    end else begin : g_off
      assign lane_scaled[l] = '0;
      assign lane_mag[l]    = '0;
    end
  end

  always_comb begin
    peak_ctl.load      = ld_out;
    peak_ctl.take_peak = (req2_r == REQ_PEAK);
    peak_ctl.meter_on  = meter_en_r;
    peak_ctl.clear     = meter_clear;
  end

  grpm_peak_merge u_merge (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (peak_ctl),
    .scaled_l (lane_scaled[0]),
    .scaled_r (lane_scaled[1]),
    .mag_l    (lane_mag[0]),
    .mag_r    (lane_mag[1]),
    .out_data (out_data)
  );

endmodule

[dv/tb.sv]
// testbench for gain_ramp_with_peak_meter_core: directed and random beats against an
// in-bench model of the gain ramp, scaling and peak meter, checked by a small scoreboard
// depends on grpm_pkg and the core rtl
`timescale 1ns / 1ps

module tb;
  import grpm_pkg::*;

  localparam int   QUIET_LIMIT  = 2000;
  localparam int   LONG_HOLD    = 80;
  localparam int   DRAIN_TAIL   = 6;
  localparam int   RANDOM_BEATS = 1450;
  localparam int   MAX_REPORTS  = 30;
  localparam smp_t SMP_MAX      = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam smp_t SMP_MIN      = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  typedef enum {SINK_FREE, SINK_LIGHT, SINK_HEAVY, SINK_PERIODIC} sink_mode_t;

  // gain ramp and peak meter model plus the queue of results it predicts
  class gain_meter_model;
    logic [CFG_W-1:0] target_gain;
    logic [CFG_W-1:0] ramp_step;
    logic             meter_on;
    logic             stereo_on;
    int               gain_now;
    mag_t             peak_hold;
    grpm_out_t        expected_out[$];
    int               errors;
    int               beats_in;
    int               peak_reqs;
    int               checked;

    function new();
      target_gain = RESET_TARGET;
      ramp_step   = RESET_STEP;
      meter_on    = 1'b0;
      stereo_on   = 1'b1;
      gain_now    = int'(UNITY_GAIN);
      peak_hold   = '0;
      errors      = 0;
      beats_in    = 0;
      peak_reqs   = 0;
      checked     = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      case (idx)
        CFG_TARGET_GAIN: target_gain = val;
        CFG_RAMP_STEP:   ramp_step = val;
        CFG_METER_ENABLE: begin
          meter_on = val[0];
          if (!val[0]) peak_hold = '0;
        end
        CFG_STEREO:      stereo_on = val[0];
        default: ;
      endcase
    endfunction

    // floor shift: arithmetic shift of the full product
    function smp_t scaled(smp_t s);
      prod_t sp;
      prod_t gp;
      prod_t p;
      sp = prod_t'(s);
      gp = prod_t'(gain_now);
      p = sp * gp;
      return smp_t'(p >>> GAIN_FRAC_BITS);
    endfunction

    function mag_t magn(smp_t v);
      if (v[SAMPLE_BITS-1]) return mag_t'(-v);
      return mag_t'(v);
    endfunction

    function void note_beat(grpm_in_t b);
      grpm_out_t r;
      int        tgt;
      int        stp;
      int        diff;
      mag_t      fpk;
      r = '0;
      beats_in++;
      if (b.req_type == REQ_PEAK) begin
        peak_reqs++;
        r.peak_level = peak_hold;
        peak_hold = '0;
      end else begin
        tgt = int'(target_gain);
        if (tgt > int'(UNITY_GAIN)) tgt = int'(UNITY_GAIN);
        stp = int'(ramp_step);
        diff = tgt - gain_now;
        if (diff > stp) gain_now += stp;
        else if (diff < -stp) gain_now -= stp;
        else gain_now = tgt;
        if (!b.left_invalid) r.left_out = scaled(b.left_sample);
        if (stereo_on && !b.right_invalid) r.right_out = scaled(b.right_sample);
        if (meter_on) begin
          fpk = magn(r.left_out);
          if (magn(r.right_out) > fpk) fpk = magn(r.right_out);
          if (fpk > peak_hold) peak_hold = fpk;
        end else begin
          peak_hold = '0;
        end
        r.peak_level = peak_hold;
      end
      expected_out.push_back(r);
    endfunction

    function void flag(string field, longint want, longint got);
      errors++;
      if (errors <= MAX_REPORTS)
        $error("%s mismatch: expected %0d, got %0d", field, want, got);
    endfunction

    function void check_beat(grpm_out_t got);
      grpm_out_t want;
      if (expected_out.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS) $error("result beat arrived with nothing expected");
        return;
      end
      want = expected_out.pop_front();
      checked++;
      if (got.left_out !== want.left_out)
        flag("left_out", longint'(want.left_out), longint'(got.left_out));
      if (got.right_out !== want.right_out)
        flag("right_out", longint'(want.right_out), longint'(got.right_out));
      if (got.peak_level !== want.peak_level)
        flag("peak_level", longint'(want.peak_level), longint'(got.peak_level));
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  grpm_in_t             in_data;
  logic                 out_valid;
  logic                 out_stall;
  grpm_out_t            out_data;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;

  gain_meter_model sb;
  grpm_in_t        burst_q[$];
  logic            long_hold_req = 1'b0;
  int              settings_done = 0;

  gain_ramp_with_peak_meter_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #10 clk = ~clk;

  // everything is sampled at the edge, before the edge's own updates land
  always @(posedge clk) begin
    if (rst_n === 1'b1) begin
      if (cfg_we) sb.write_reg(cfg_index, cfg_wdata);
      if (in_valid && !in_stall) sb.note_beat(in_data);
      if (out_valid && !out_stall) sb.check_beat(out_data);
    end
  end

  function automatic grpm_in_t make_beat(logic req, smp_t l, smp_t r, logic li, logic ri);
    grpm_in_t b;
    b.req_type      = req;
    b.left_sample   = l;
    b.right_sample  = r;
    b.left_invalid  = li;
    b.right_invalid = ri;
    return b;
  endfunction

  function automatic smp_t pick_sample();
    case ($urandom_range(0, 7))
      0:       return SMP_MAX;
      1:       return SMP_MIN;
      2:       return smp_t'(int'($urandom_range(0, 64)) - 32);
      default: return smp_t'($urandom);
    endcase
  endfunction

  task automatic queue_beat(logic req, smp_t l, smp_t r, logic li, logic ri);
    burst_q.push_back(make_beat(req, l, r, li, ri));
  endtask

  // offers the queued beats back to back, each held until taken
  task automatic send_burst();
    foreach (burst_q[i]) begin
      in_data  <= burst_q[i];
      in_valid <= 1'b1;
      do @(posedge clk); while (in_stall);
    end
    burst_q.delete();
  endtask

  task automatic idle_gap(int n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_out.size() != 0) @(posedge clk);
    repeat (DRAIN_TAIL) @(posedge clk);
  endtask

  task automatic apply_settings(logic [CFG_W-1:0] tg, logic [CFG_W-1:0] rs,
                                logic me, logic st);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_TARGET_GAIN;
    cfg_wdata <= tg;
    @(posedge clk);
    cfg_index <= CFG_RAMP_STEP;
    cfg_wdata <= rs;
    @(posedge clk);
    cfg_index <= CFG_METER_ENABLE;
    cfg_wdata <= CFG_W'(me);
    @(posedge clk);
    cfg_index <= CFG_STEREO;
    cfg_wdata <= CFG_W'(st);
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_done++;
  endtask

  // result side: changing stall patterns, plus a long hold on request
  initial begin : result_sink
    sink_mode_t mode;
    int         left_in_mode;
    int         tick;
    out_stall <= 1'b0;
    mode = SINK_FREE;
    left_in_mode = 0;
    tick = 0;
    forever begin
      @(posedge clk);
      tick++;
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        if (left_in_mode == 0) begin
          mode = sink_mode_t'($urandom_range(0, 3));
          left_in_mode = $urandom_range(20, 200);
        end
        left_in_mode--;
        case (mode)
          SINK_FREE:  out_stall <= 1'b0;
          SINK_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
          SINK_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
          default:    out_stall <= ((tick % 7) < 3);
        endcase
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst_n !== 1'b1 || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
        quiet = 0;
      else
        quiet++;
    end
    $error("no beat moved for %0d cycles", QUIET_LIMIT);
    $display("tb: FAIL");
    $finish;
  end

  initial begin : stimulus
    logic [CFG_W-1:0] tg;
    logic [CFG_W-1:0] rs;
    logic             me;
    logic             st;
    grpm_in_t         b;
    int               random_sent;
    int               phase_no;
    int               phase_left;
    int               len;
    sb = new();
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset defaults: unity gain, meter off, stereo
    queue_beat(REQ_AUDIO, SMP_MAX, SMP_MIN, 1'b0, 1'b0);
    queue_beat(REQ_AUDIO, 24'sd12345, -24'sd777, 1'b0, 1'b0);
    queue_beat(REQ_PEAK, SMP_MAX, SMP_MAX, 1'b0, 1'b0);
    send_burst();
    wait_for_results();

    // extremes, invalid flags and peak take at unity
    apply_settings(UNITY_GAIN, RESET_STEP, 1'b1, 1'b1);
    queue_beat(REQ_AUDIO, SMP_MAX, SMP_MAX, 1'b0, 1'b0);
    queue_beat(REQ_AUDIO, SMP_MIN, SMP_MIN, 1'b0, 1'b0);
    queue_beat(REQ_PEAK, SMP_MIN, SMP_MAX, 1'b1, 1'b1);
    queue_beat(REQ_PEAK, 24'sd0, 24'sd0, 1'b0, 1'b0);
    queue_beat(REQ_AUDIO, SMP_MAX, -24'sd1, 1'b1, 1'b0);
    queue_beat(REQ_AUDIO, 24'sd5, SMP_MIN, 1'b0, 1'b1);
    queue_beat(REQ_AUDIO, SMP_MIN, SMP_MIN, 1'b1, 1'b1);
    send_burst();
    wait_for_results();

    // mono ramp down, with a peak take in the middle of the ramp
    apply_settings(16'd0, 16'd5000, 1'b1, 1'b0);
    queue_beat(REQ_AUDIO, SMP_MAX, SMP_MIN, 1'b0, 1'b0);
    queue_beat(REQ_AUDIO, SMP_MIN, SMP_MAX, 1'b0, 1'b1);
    queue_beat(REQ_PEAK, SMP_MAX, SMP_MAX, 1'b0, 1'b0);
    queue_beat(REQ_AUDIO, SMP_MAX, SMP_MIN, 1'b0, 1'b0);
    queue_beat(REQ_AUDIO, -24'sd3, SMP_MIN, 1'b0, 1'b0);
    send_burst();
    wait_for_results();

    // target above unity with zero step: gain must hold
    apply_settings(16'hFFFF, 16'd0, 1'b1, 1'b1);
    queue_beat(REQ_AUDIO, SMP_MAX, SMP_MIN, 1'b0, 1'b0);
    queue_beat(REQ_AUDIO, SMP_MIN, SMP_MAX, 1'b0, 1'b0);
    send_burst();
    wait_for_results();

    // full step snaps to the clamped target; meter off clears the peak
    apply_settings(16'hFFFF, 16'd32768, 1'b0, 1'b1);
    queue_beat(REQ_AUDIO, SMP_MIN, SMP_MAX, 1'b0, 1'b0);
    queue_beat(REQ_PEAK, SMP_MIN, SMP_MAX, 1'b0, 1'b0);
    send_burst();
    wait_for_results();

    // smallest gain: floor rounding of negative products
    apply_settings(16'd1, 16'd32768, 1'b1, 1'b1);
    queue_beat(REQ_AUDIO, SMP_MIN, -24'sd1, 1'b0, 1'b0);
    queue_beat(REQ_AUDIO, 24'sd100, SMP_MAX, 1'b0, 1'b0);
    send_burst();
    wait_for_results();

    random_sent = 0;
    phase_no = 0;
    while (random_sent < RANDOM_BEATS) begin
      case ($urandom_range(0, 5))
        0:       tg = '0;
        1:       tg = UNITY_GAIN;
        2:       tg = CFG_W'($urandom_range(32769, 65535));
        default: tg = CFG_W'($urandom_range(0, 32768));
      endcase
      case ($urandom_range(0, 6))
        0:       rs = '0;
        1:       rs = 16'd1;
        2:       rs = 16'd32768;
        3:       rs = CFG_W'($urandom_range(32769, 65535));
        default: rs = CFG_W'($urandom_range(1, 3000));
      endcase
      me = ($urandom_range(0, 3) != 0);
      st = ($urandom_range(0, 2) != 0);
      apply_settings(tg, rs, me, st);
      // fill the pipeline against a held-off receiver now and then
      if (phase_no % 5 == 2) long_hold_req = 1'b1;
      phase_left = $urandom_range(40, 180);
      if (phase_left > RANDOM_BEATS - random_sent) phase_left = RANDOM_BEATS - random_sent;
      while (phase_left > 0) begin
        len = $urandom_range(1, 24);
        if (len > phase_left) len = phase_left;
        repeat (len) begin
          b.req_type      = ($urandom_range(0, 99) < 12) ? REQ_PEAK : REQ_AUDIO;
          b.left_sample   = pick_sample();
          b.right_sample  = pick_sample();
          b.left_invalid  = ($urandom_range(0, 9) == 0);
          b.right_invalid = ($urandom_range(0, 9) == 0);
          burst_q.push_back(b);
        end
        send_burst();
        phase_left -= len;
        random_sent += len;
        if ($urandom_range(0, 9) >= 3) idle_gap($urandom_range(1, 12));
      end
      wait_for_results();
      phase_no++;
    end

    $display("summary: %0d beats in (%0d peak takes), %0d results checked, %0d settings",
             sb.beats_in, sb.peak_reqs, sb.checked, settings_done);
    if (sb.errors == 0 && sb.expected_out.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
